@@ design/mesi_pkg.sv @@
// Shared types and constants of the MESI directory controller.
package mesi_pkg;

    localparam int CORES       = 4;
    localparam int DIR_ENTRIES = 64;
    localparam int CORE_W      = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int IDX_W       = $clog2(DIR_ENTRIES);
    localparam int CNT_W       = $clog2(DIR_ENTRIES + 1);
    localparam int ST_VEC_W    = 2 * CORES;

    // Request codes.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_EVICT = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    // Line states.
    localparam logic [1:0] ST_I = 2'd0;
    localparam logic [1:0] ST_S = 2'd1;
    localparam logic [1:0] ST_E = 2'd2;
    localparam logic [1:0] ST_M = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OFFSET = 2'd0;
    localparam logic [1:0] CFG_SNOOP  = 2'd1;
    localparam logic [1:0] CFG_XFER   = 2'd2;
    localparam logic [1:0] CFG_INVAL  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request and clear accumulators
        logic scan_step;  // read the tag at the scan pointer, compare the previous one
        logic read_entry; // issue a memory read of the hit or free entry
        logic core_step;  // examine one core state of the fetched entry
        logic commit;     // write back the entry and present the result
        logic fail;       // present an all-zero or full result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic found;
        logic has_free;
        logic core_bad;
        logic core_done;
    } t_status;

endpackage

@@ design/mesi_ctrl.sv @@
// Sequencing state machine of the MESI directory controller.
module mesi_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_req_type,
    input  mesi_pkg::t_status  i_status,
    output logic               o_busy,
    output mesi_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_CORES = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_type;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (i_start && r_state == S_IDLE) begin
            r_type <= i_req_type;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.core_bad) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_DONE;
                end else if (i_status.scan_done) begin
                    if (i_status.found) begin
                        n_state = S_READ;
                    end else if ((r_type == mesi_pkg::REQ_READ ||
                                  r_type == mesi_pkg::REQ_WRITE) && i_status.has_free) begin
                        n_state = S_READ;
                    end else begin
                        o_cmd.fail = 1'b1;
                        n_state    = S_DONE;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.read_entry = 1'b1;
                n_state          = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_CORES;
            end
            S_CORES: begin
                if (i_status.core_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.core_step = 1'b1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/mesi_dp.sv @@
// Datapath of the MESI directory: entry table, tag search, core scan and result.
module mesi_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_req_type,
    input  logic [1:0]            i_core_index,
    input  logic [31:0]           i_byte_address,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data,
    input  mesi_pkg::t_cmd        i_cmd,
    output mesi_pkg::t_status     o_status,
    output logic                  o_valid,
    output logic [1:0]            o_requester_state,
    output logic [11:0]           o_latency_cycles,
    output logic [3:0]            o_invalidate_mask,
    output logic [3:0]            o_writeback_mask,
    output logic                  o_share_valid,
    output logic [1:0]            o_share_source,
    output logic                  o_directory_full
);

    localparam int CORES = mesi_pkg::CORES;
    localparam int DE    = mesi_pkg::DIR_ENTRIES;
    localparam int IW    = mesi_pkg::IDX_W;
    localparam int CW    = mesi_pkg::CNT_W;
    localparam int KW    = mesi_pkg::CORE_W;
    localparam int KCW   = $clog2(CORES + 1);
    localparam int SW    = mesi_pkg::ST_VEC_W;

    // Configuration registers.
    logic [3:0] r_offset;
    logic [7:0] r_snoop, r_xfer, r_inval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= 4'd6;
            r_snoop  <= 8'd10;
            r_xfer   <= 8'd20;
            r_inval  <= 8'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mesi_pkg::CFG_OFFSET: r_offset <= i_cfg_data[3:0];
                mesi_pkg::CFG_SNOOP:  r_snoop  <= i_cfg_data;
                mesi_pkg::CFG_XFER:   r_xfer   <= i_cfg_data;
                mesi_pkg::CFG_INVAL:  r_inval  <= i_cfg_data;
            endcase
        end
    end

    // Directory storage: valid bits in flops, tags and states in memories.
    logic [DE-1:0] r_valid;
    logic [31:0]   m_tag   [DE];
    logic [SW-1:0] m_state [DE];

    logic [31:0]   r_tag_rd;
    logic [SW-1:0] r_st_rd;

    // Request registers.
    logic [1:0]  r_type;
    logic [KW-1:0] r_core;
    logic        r_core_bad;
    logic [31:0] r_tag;
    logic [CW-1:0] r_ptr;
    logic        r_found;
    logic [IW-1:0] r_hit_idx;
    logic        r_has_free;
    logic [IW-1:0] r_free_idx;
    logic        r_tag_vld;  // r_tag_rd holds entry r_ptr-1

    // Core scan registers.
    logic [SW-1:0] r_st;
    logic [KCW-1:0] r_ci;
    logic [1:0]  r_cur;
    logic        r_owner_v, r_sharer_v;
    logic [KW-1:0] r_owner, r_sharer;
    logic [3:0]  r_inv, r_wb;
    logic [11:0] r_lat;
    logic        r_scan_go;

    logic [31:0] n_tag;
    logic [IW-1:0] w_idx;
    logic        w_last_cmp;
    logic [SW-1:0] w_commit_st;

    assign n_tag = i_byte_address & ~((32'd1 << r_offset) - 32'd1);
    assign w_idx = r_found ? r_hit_idx : r_free_idx;

    // The tag memory read is registered, so the compared tag is the entry before the scan pointer.
    assign w_last_cmp = r_tag_vld && (r_ptr == CW'(DE));

    // The final state vector is what commit stores; compute it combinationally.
    always_comb begin
        w_commit_st = r_st;
        unique case (r_type)
            mesi_pkg::REQ_READ: begin
                if (r_cur == mesi_pkg::ST_M) begin
                    w_commit_st = r_st;
                end else if (r_owner_v) begin
                    w_commit_st[2*r_owner +: 2] = mesi_pkg::ST_S;
                    w_commit_st[2*r_core +: 2]  = mesi_pkg::ST_S;
                end else if (r_sharer_v) begin
                    w_commit_st[2*r_sharer +: 2] = mesi_pkg::ST_S;
                    w_commit_st[2*r_core +: 2]   = mesi_pkg::ST_S;
                end else begin
                    w_commit_st[2*r_core +: 2] = mesi_pkg::ST_E;
                end
            end
            mesi_pkg::REQ_WRITE: w_commit_st[2*r_core +: 2] = mesi_pkg::ST_M;
            mesi_pkg::REQ_EVICT: w_commit_st[2*r_core +: 2] = mesi_pkg::ST_I;
            mesi_pkg::REQ_QUERY: w_commit_st = r_st;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && r_ptr < CW'(DE)) begin
            r_tag_rd <= m_tag[r_ptr[IW-1:0]];
        end
        if (i_cmd.read_entry) begin
            r_st_rd <= m_state[w_idx];
        end
        if (i_cmd.commit && !r_core_bad) begin
            if (!r_found) begin
                m_tag[w_idx] <= r_tag;
            end
            m_state[w_idx] <= w_commit_st;
        end
    end

    // Search: one tag compared per cycle, lowest hit and lowest free kept.
    always_ff @(posedge i_clk) begin
        logic [IW-1:0] v_prev;
        v_prev = IW'(r_ptr - CW'(1));
        if (i_cmd.load) begin
            r_type     <= i_req_type;
            r_core     <= KW'(i_core_index);
            r_core_bad <= (32'(i_core_index) >= 32'(CORES));
            r_tag      <= n_tag;
            r_ptr      <= '0;
            r_found    <= 1'b0;
            r_has_free <= 1'b0;
            r_tag_vld  <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (r_tag_vld) begin
                if (r_valid[v_prev] && r_tag_rd == r_tag && !r_found) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= v_prev;
                end
                if (!r_valid[v_prev] && !r_has_free) begin
                    r_has_free <= 1'b1;
                    r_free_idx <= v_prev;
                end
            end
            r_tag_vld <= 1'b1;
            if (r_ptr < CW'(DE)) begin
                r_ptr <= r_ptr + CW'(1);
            end
        end
    end

    assign o_status.scan_done = w_last_cmp && r_scan_go;
    assign o_status.found     = r_found;
    assign o_status.has_free  = r_has_free;
    assign o_status.core_bad  = r_core_bad;
    assign o_status.core_done = (r_ci == KCW'(CORES + 1));

    // r_scan_go marks that the final comparison has been folded in.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scan_go <= 1'b0;
        end else if (i_cmd.scan_step && w_last_cmp) begin
            r_scan_go <= 1'b1;
        end
    end

    // Core scan: index 0 loads the entry, then one core per cycle, then decide.
    always_ff @(posedge i_clk) begin
        logic [KW-1:0] v_c;
        logic [1:0]    v_s;
        logic [SW-1:0] v_st;
        logic [11:0]   v_lat;
        v_c  = KW'(r_ci - KCW'(1));
        v_s  = r_st[2*v_c +: 2];
        v_st = r_st;
        v_lat = r_lat;
        if (i_cmd.load) begin
            r_ci <= '0;
        end else if (i_cmd.core_step) begin
            if (r_ci == '0) begin
                v_st = r_found ? r_st_rd : '0;
                r_st       <= v_st;
                r_cur      <= v_st[2*r_core +: 2];
                r_owner_v  <= 1'b0;
                r_sharer_v <= 1'b0;
                r_inv      <= '0;
                r_wb       <= '0;
                r_lat      <= {4'd0, r_snoop};
            end else if (r_ci <= KCW'(CORES)) begin
                if (v_c != r_core) begin
                    if (!r_owner_v && v_s == mesi_pkg::ST_M) begin
                        r_owner_v <= 1'b1;
                        r_owner   <= v_c;
                    end
                    if (!r_sharer_v && (v_s == mesi_pkg::ST_S || v_s == mesi_pkg::ST_E)) begin
                        r_sharer_v <= 1'b1;
                        r_sharer   <= v_c;
                    end
                    // Invalidation work applies only to a write from S or I.
                    if (r_type == mesi_pkg::REQ_WRITE && r_cur != mesi_pkg::ST_M &&
                        r_cur != mesi_pkg::ST_E && v_s != mesi_pkg::ST_I) begin
                        if (v_s == mesi_pkg::ST_M) begin
                            if (32'(v_c) < 4) r_wb[2'(v_c)] <= 1'b1;
                            v_lat = v_lat + {4'd0, r_xfer};
                        end else begin
                            v_lat = v_lat + {4'd0, r_inval};
                        end
                        if (32'(v_c) < 4) r_inv[2'(v_c)] <= 1'b1;
                        v_st[2*v_c +: 2] = mesi_pkg::ST_I;
                        r_st  <= v_st;
                        r_lat <= v_lat;
                    end
                end
            end
            r_ci <= r_ci + KCW'(1);
        end
    end

    // Valid bits and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.commit || i_cmd.fail;
            if (i_cmd.fail) begin
                o_requester_state <= mesi_pkg::ST_I;
                o_latency_cycles  <= '0;
                o_invalidate_mask <= '0;
                o_writeback_mask  <= '0;
                o_share_valid     <= 1'b0;
                o_share_source    <= '0;
                o_directory_full  <= !r_core_bad && !r_found &&
                                     (r_type == mesi_pkg::REQ_READ ||
                                      r_type == mesi_pkg::REQ_WRITE);
            end else if (i_cmd.commit) begin
                o_requester_state <= mesi_pkg::ST_I;
                o_latency_cycles  <= '0;
                o_invalidate_mask <= '0;
                o_writeback_mask  <= '0;
                o_share_valid     <= 1'b0;
                o_share_source    <= '0;
                o_directory_full  <= 1'b0;
                unique case (r_type)
                    mesi_pkg::REQ_READ: begin
                        o_latency_cycles <= {4'd0, r_snoop};
                        if (r_cur == mesi_pkg::ST_M) begin
                            o_requester_state <= mesi_pkg::ST_M;
                        end else if (r_owner_v) begin
                            if (32'(r_owner) < 4) o_writeback_mask[2'(r_owner)] <= 1'b1;
                            o_share_valid     <= 1'b1;
                            o_share_source    <= 2'(r_owner);
                            o_latency_cycles  <= {4'd0, r_snoop} + {4'd0, r_xfer};
                            o_requester_state <= mesi_pkg::ST_S;
                        end else if (r_sharer_v) begin
                            o_requester_state <= mesi_pkg::ST_S;
                        end else begin
                            o_requester_state <= mesi_pkg::ST_E;
                        end
                    end
                    mesi_pkg::REQ_WRITE: begin
                        o_requester_state <= mesi_pkg::ST_M;
                        if (r_cur != mesi_pkg::ST_M && r_cur != mesi_pkg::ST_E) begin
                            o_latency_cycles  <= r_lat;
                            o_invalidate_mask <= r_inv;
                            o_writeback_mask  <= r_wb;
                        end
                    end
                    mesi_pkg::REQ_EVICT: begin
                        o_requester_state <= mesi_pkg::ST_I;
                    end
                    mesi_pkg::REQ_QUERY: begin
                        o_requester_state <= r_cur;
                    end
                endcase
                r_valid[w_idx] <= (w_commit_st != '0) || (r_type != mesi_pkg::REQ_EVICT);
            end
        end
    end

endmodule

@@ design/mesi_directory_controller.sv @@
// Top level of the MESI coherence directory controller.
//
// One request is taken at a rising edge where i_start is high and o_busy is
// low; its result appears for exactly one cycle with o_done and cannot be
// stalled. A request that finds or allocates an entry shows its result after
// the tag search, the entry read and the core scan; o_busy stays high while
// o_done is shown and falls after it, so the next request is taken only then.
// An eviction or query of an untracked line, or a miss that finds the
// directory full, ends after the search and shows its result with no core
// scan. The tag search compares one directory entry per cycle through the tag
// memory's single read port, then the core states of the entry are examined
// one core per cycle.
module mesi_directory_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_core_index,
    input  logic [31:0] i_byte_address,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_done,
    output logic [1:0]  o_requester_state,
    output logic [11:0] o_latency_cycles,
    output logic [3:0]  o_invalidate_mask,
    output logic [3:0]  o_writeback_mask,
    output logic        o_share_valid,
    output logic [1:0]  o_share_source,
    output logic        o_directory_full
);

    mesi_pkg::t_cmd    w_cmd;
    mesi_pkg::t_status w_status;

    mesi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_status   (w_status),
        .o_busy     (o_busy),
        .o_cmd      (w_cmd)
    );

    mesi_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_type        (i_req_type),
        .i_core_index      (i_core_index),
        .i_byte_address    (i_byte_address),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_valid           (o_done),
        .o_requester_state (o_requester_state),
        .o_latency_cycles  (o_latency_cycles),
        .o_invalidate_mask (o_invalidate_mask),
        .o_writeback_mask  (o_writeback_mask),
        .o_share_valid     (o_share_valid),
        .o_share_source    (o_share_source),
        .o_directory_full  (o_directory_full)
    );

endmodule

@@ design/mesi_checker.sv @@
// Port-level checker for the MESI directory controller, bound to the top level.
module mesi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [1:0]  o_requester_state,
    input logic [11:0] o_latency_cycles,
    input logic [3:0]  o_invalidate_mask,
    input logic [3:0]  o_writeback_mask,
    input logic        o_share_valid,
    input logic        o_directory_full
);

    // A request is always in flight when its result is shown.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("result without a request in flight");

    // A full directory result carries no latency, invalidations or requester state.
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_directory_full) |-> (o_latency_cycles == 12'd0 &&
        o_invalidate_mask == 4'd0 && o_requester_state == 2'd0))
        else $error("full result has payload");

    // A supplied line always comes with that owner's writeback.
    a_share_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_share_valid) |-> (o_writeback_mask != 4'd0 &&
        o_requester_state == 2'd1)) else $error("sharing without writeback");

    // Accepting a request makes the block busy.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("request not taken");

    // Writebacks are a subset of invalidations except on a read transfer.
    a_wb_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_share_valid) |-> ((o_writeback_mask & ~o_invalidate_mask) == 4'd0))
        else $error("writeback without invalidate");

endmodule

bind mesi_directory_controller mesi_checker u_mesi_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_start           (i_start),
    .o_busy            (o_busy),
    .o_done            (o_done),
    .o_requester_state (o_requester_state),
    .o_latency_cycles  (o_latency_cycles),
    .o_invalidate_mask (o_invalidate_mask),
    .o_writeback_mask  (o_writeback_mask),
    .o_share_valid     (o_share_valid),
    .o_directory_full  (o_directory_full)
);

@@ tb/tb_mesi_directory_controller.sv @@
// Self-checking testbench of the MESI directory controller against a behavioral directory.
module tb_mesi_directory_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic [1:0]  rstate;
        logic [11:0] lat;
        logic [3:0]  inv;
        logic [3:0]  wb;
        logic        shv;
        logic [1:0]  shs;
        logic        full;
    } t_coh_result;

    logic        i_clk, i_rst_n, i_start, o_busy;
    logic [1:0]  i_req_type, i_core_index;
    logic [31:0] i_byte_address;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        o_done;
    logic [1:0]  o_requester_state;
    logic [11:0] o_latency_cycles;
    logic [3:0]  o_invalidate_mask, o_writeback_mask;
    logic        o_share_valid;
    logic [1:0]  o_share_source;
    logic        o_directory_full;

    mesi_directory_controller u_dut (.*);

    // Shadow directory and configuration.
    logic [3:0]  sh_offset;
    logic [7:0]  sh_snoop, sh_xfer, sh_inval;
    logic        dir_valid  [mesi_pkg::DIR_ENTRIES];
    logic [31:0] dir_tag    [mesi_pkg::DIR_ENTRIES];
    logic [7:0]  dir_states [mesi_pkg::DIR_ENTRIES];

    t_coh_result pending_results[$];
    int          error_count;
    int          idle_cycles;
    int          send_idle_pct;
    logic [31:0] addr_pool[8];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch %s: got %0h expected %0h", what, got, exp_val);
        error_count++;
    endtask

    function automatic logic [1:0] st_of(int e, int c);
        return dir_states[e][2*c +: 2];
    endfunction

    function automatic void st_set(int e, int c, logic [1:0] s);
        dir_states[e][2*c +: 2] = s;
    endfunction

    function automatic t_coh_result predict_coherence(logic [1:0] kind, logic [1:0] core,
                                                       logic [31:0] addr);
        t_coh_result r;
        logic [31:0] tag;
        logic [1:0]  cur;
        int f, owner, sharer;
        r = '0;
        tag = addr & ~((32'd1 << sh_offset) - 32'd1);
        f = -1;
        for (int i = 0; i < mesi_pkg::DIR_ENTRIES; i++)
            if (f < 0 && dir_valid[i] && dir_tag[i] == tag) f = i;
        if ((kind == mesi_pkg::REQ_READ || kind == mesi_pkg::REQ_WRITE) && f < 0) begin
            for (int i = 0; i < mesi_pkg::DIR_ENTRIES; i++)
                if (f < 0 && !dir_valid[i]) begin
                    f = i;
                    dir_valid[i] = 1'b1;
                    dir_tag[i] = tag;
                    dir_states[i] = '0;
                end
            if (f < 0) r.full = 1'b1;
        end
        if (f < 0) return r;
        cur = st_of(f, core);
        case (kind)
            mesi_pkg::REQ_READ: begin
                owner = -1;
                sharer = -1;
                r.lat = 12'(sh_snoop);
                for (int i = 0; i < mesi_pkg::CORES; i++) begin
                    if (i == core) continue;
                    if (owner < 0 && st_of(f, i) == mesi_pkg::ST_M) owner = i;
                    if (sharer < 0 && (st_of(f, i) == mesi_pkg::ST_S ||
                                       st_of(f, i) == mesi_pkg::ST_E)) sharer = i;
                end
                if (cur == mesi_pkg::ST_M) begin
                    r.rstate = mesi_pkg::ST_M;
                end else if (owner >= 0) begin
                    st_set(f, owner, mesi_pkg::ST_S);
                    st_set(f, core, mesi_pkg::ST_S);
                    r.wb = 4'(1 << owner);
                    r.shv = 1'b1;
                    r.shs = 2'(owner);
                    r.lat = r.lat + 12'(sh_xfer);
                    r.rstate = mesi_pkg::ST_S;
                end else if (sharer >= 0) begin
                    st_set(f, sharer, mesi_pkg::ST_S);
                    st_set(f, core, mesi_pkg::ST_S);
                    r.rstate = mesi_pkg::ST_S;
                end else begin
                    st_set(f, core, mesi_pkg::ST_E);
                    r.rstate = mesi_pkg::ST_E;
                end
            end
            mesi_pkg::REQ_WRITE: begin
                if (cur != mesi_pkg::ST_M && cur != mesi_pkg::ST_E) begin
                    r.lat = 12'(sh_snoop);
                    for (int i = 0; i < mesi_pkg::CORES; i++) begin
                        if (i == core || st_of(f, i) == mesi_pkg::ST_I) continue;
                        if (st_of(f, i) == mesi_pkg::ST_M) begin
                            r.wb[i] = 1'b1;
                            r.lat = r.lat + 12'(sh_xfer);
                        end else begin
                            r.lat = r.lat + 12'(sh_inval);
                        end
                        r.inv[i] = 1'b1;
                        st_set(f, i, mesi_pkg::ST_I);
                    end
                end
                st_set(f, core, mesi_pkg::ST_M);
                r.rstate = mesi_pkg::ST_M;
            end
            mesi_pkg::REQ_EVICT: begin
                st_set(f, core, mesi_pkg::ST_I);
                if (dir_states[f] == '0) dir_valid[f] = 1'b0;
            end
            default: r.rstate = cur;
        endcase
        return r;
    endfunction

    // Called at a falling edge; o_busy is stable there and holds until the next rising edge.
    task automatic send_request(input logic [1:0] kind, input logic [1:0] core,
                                input logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        i_start        <= 1'b1;
        i_req_type     <= kind;
        i_core_index   <= core;
        i_byte_address <= addr;
        pending_results.push_back(predict_coherence(kind, core, addr));
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [1:0] idx, input logic [7:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            mesi_pkg::CFG_OFFSET: sh_offset = val[3:0];
            mesi_pkg::CFG_SNOOP:  sh_snoop  = val;
            mesi_pkg::CFG_XFER:   sh_xfer   = val;
            default:              sh_inval  = val;
        endcase
    endtask

    // Checker: every done strobe is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && (o_done || i_start && !o_busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                t_coh_result e;
                e = pending_results.pop_front();
                if (o_requester_state !== e.rstate)
                    report_mismatch("requester_state", o_requester_state, e.rstate);
                if (o_latency_cycles !== e.lat)
                    report_mismatch("latency_cycles", o_latency_cycles, e.lat);
                if (o_invalidate_mask !== e.inv)
                    report_mismatch("invalidate_mask", o_invalidate_mask, e.inv);
                if (o_writeback_mask !== e.wb)
                    report_mismatch("writeback_mask", o_writeback_mask, e.wb);
                if (o_share_valid !== e.shv)
                    report_mismatch("share_valid", o_share_valid, e.shv);
                if (o_share_source !== e.shs)
                    report_mismatch("share_source", o_share_source, e.shs);
                if (o_directory_full !== e.full)
                    report_mismatch("directory_full", o_directory_full, e.full);
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** mesi_directory_controller: FAILED **");
            $finish;
        end
    end

    // Directed: every request kind and the classic MESI transitions.
    task automatic test_directed_protocol();
        send_request(mesi_pkg::REQ_QUERY, 2'd0, 32'h0000_0040);
        send_request(mesi_pkg::REQ_EVICT, 2'd1, 32'h0000_0040);
        send_request(mesi_pkg::REQ_READ,  2'd0, 32'h0000_0047);
        send_request(mesi_pkg::REQ_READ,  2'd0, 32'h0000_0040);
        send_request(mesi_pkg::REQ_READ,  2'd1, 32'h0000_0041);
        send_request(mesi_pkg::REQ_WRITE, 2'd2, 32'h0000_0040);
        send_request(mesi_pkg::REQ_READ,  2'd3, 32'h0000_007F);
        send_request(mesi_pkg::REQ_WRITE, 2'd3, 32'h0000_0040);
        send_request(mesi_pkg::REQ_WRITE, 2'd3, 32'h0000_0040);
        send_request(mesi_pkg::REQ_READ,  2'd1, 32'hFFFF_FFFF);
        send_request(mesi_pkg::REQ_WRITE, 2'd1, 32'hFFFF_FFC0);
        send_request(mesi_pkg::REQ_QUERY, 2'd1, 32'hFFFF_FFFF);
        for (int c = 0; c < mesi_pkg::CORES; c++)
            send_request(mesi_pkg::REQ_EVICT, 2'(c), 32'h0000_0040);
        send_request(mesi_pkg::REQ_EVICT, 2'd1, 32'hFFFF_FFFF);
        send_request(mesi_pkg::REQ_QUERY, 2'd1, 32'hFFFF_FFFF);
    endtask

    // Fill every entry, hit the full case, then release the table.
    task automatic test_directory_full();
        for (int i = 0; i <= mesi_pkg::DIR_ENTRIES; i++)
            send_request(mesi_pkg::REQ_WRITE, 2'($urandom_range(3)),
                         32'h1000_0000 + 32'(i) * 32'h100);
        send_request(mesi_pkg::REQ_READ, 2'd2, 32'h2000_0000);
        for (int i = 0; i < mesi_pkg::DIR_ENTRIES; i++)
            for (int c = 0; c < mesi_pkg::CORES; c++)
                send_request(mesi_pkg::REQ_EVICT, 2'(c), 32'h1000_0000 + 32'(i) * 32'h100);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct);
        logic [31:0] a;
        send_idle_pct = idle_pct;
        for (int i = 0; i < 8; i++) addr_pool[i] = $urandom();
        for (int n = 0; n < count; n++) begin
            a = addr_pool[$urandom_range(7)];
            if ($urandom_range(9) == 0) a = $urandom();
            else a = a ^ 32'($urandom_range(63));
            send_request(2'($urandom_range(3)), 2'($urandom_range(3)), a);
        end
        send_idle_pct = 0;
    endtask

    initial begin
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req_type = '0;
        i_core_index = '0;
        i_byte_address = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        sh_offset = 4'd6;
        sh_snoop = 8'd10;
        sh_xfer = 8'd20;
        sh_inval = 8'd5;
        for (int i = 0; i < mesi_pkg::DIR_ENTRIES; i++) begin
            dir_valid[i] = 1'b0;
            dir_tag[i] = '0;
            dir_states[i] = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_protocol();
        test_directory_full();
        test_random_traffic(70, 0);
        write_config(mesi_pkg::CFG_OFFSET, 8'd2);
        write_config(mesi_pkg::CFG_SNOOP, 8'd255);
        write_config(mesi_pkg::CFG_XFER, 8'd255);
        write_config(mesi_pkg::CFG_INVAL, 8'd255);
        test_random_traffic(70, 66);
        write_config(mesi_pkg::CFG_OFFSET, 8'd12);
        write_config(mesi_pkg::CFG_SNOOP, 8'd0);
        write_config(mesi_pkg::CFG_XFER, 8'd0);
        write_config(mesi_pkg::CFG_INVAL, 8'd0);
        test_random_traffic(70, 32);
        // Offsets outside the usual range are taken as given.
        write_config(mesi_pkg::CFG_OFFSET, 8'd15);
        write_config(mesi_pkg::CFG_SNOOP, 8'($urandom()));
        write_config(mesi_pkg::CFG_XFER, 8'($urandom()));
        write_config(mesi_pkg::CFG_INVAL, 8'($urandom()));
        test_random_traffic(50, 66);
        write_config(mesi_pkg::CFG_OFFSET, 8'd0);
        test_random_traffic(50, 0);

        wait_idle();
        if (error_count == 0) begin
            $display("** mesi_directory_controller: PASSED **");
        end else begin
            $display("** mesi_directory_controller: FAILED **");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
design/mesi_pkg.sv
design/mesi_ctrl.sv
design/mesi_dp.sv
design/mesi_directory_controller.sv
design/mesi_checker.sv
tb/tb_mesi_directory_controller.sv
